// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level, bounded_undo_history.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define AST_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AST_INVAR(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define AST_PROP(lbl, clk, rst_n, prop, msg)
`define AST_INVAR(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/buh_pkg.sv =====
// Types, constants and helpers of the bounded undo history.
package buh_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int TAG_BITS      = 16;
    localparam int PTR_W         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int CFG_W         = 7;
    localparam int TAG_OUT_W     = 16;
    localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(64);

    typedef logic [PTR_W-1:0]    t_ptr;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [TAG_BITS-1:0] t_tag;

    typedef enum logic [2:0] {
        REQ_PUSH  = 3'd0,
        REQ_UNDO  = 3'd1,
        REQ_REDO  = 3'd2,
        REQ_MARK  = 3'd3,
        REQ_CLEAR = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic we;
        t_ptr waddr;
        t_tag wdata;
        t_ptr raddr_a;
        t_ptr raddr_b;
    } t_ring_req;

    // (oldest + pos) mod depth; pos never reaches twice the depth when it is used
    function automatic t_ptr slot_of(input t_ptr oldest, input t_cnt pos);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(oldest) + (CNT_W+1)'(pos);
        if (s >= (CNT_W+1)'(HISTORY_DEPTH)) begin
            s = s - (CNT_W+1)'(HISTORY_DEPTH);
        end
        return PTR_W'(s);
    endfunction

    // zero acts as one, anything above the ring size as the ring size
    function automatic t_cnt eff_limit(input logic [CFG_W-1:0] v);
        t_cnt lim;
        if (32'(v) > HISTORY_DEPTH) begin
            lim = CNT_W'(HISTORY_DEPTH);
        end else if (v == '0) begin
            lim = CNT_W'(1);
        end else begin
            lim = CNT_W'(v);
        end
        return lim;
    endfunction

endpackage

// ===== rtl/buh_ring.sv =====
// Tag ring: one write port, two registered read ports.
module buh_ring
    import buh_pkg::*;
(
    input  logic      i_clk,
    input  t_ring_req i_req,
    output t_tag      o_rd_a,
    output t_tag      o_rd_b
);

    t_tag r_mem [HISTORY_DEPTH];
    t_tag r_rd_a;
    t_tag r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_req.raddr_a];
        r_rd_b <= r_mem[i_req.raddr_b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// ===== rtl/bounded_undo_history.sv =====
// Bounded undo/redo history: top level with pointer logic and result register.
//
// Requests (push, undo, redo, mark save point, clear) arrive one transaction at a
// time and each returns one result. The pointers and the ring write settle in the
// accept cycle, the ring is read at the undo and redo slots in ST_READ, and the
// result is registered in ST_RESP once the output register is free. The input is
// ready again in the cycle after the result register is loaded, so a new request
// is not taken until the last one's result has been loaded. history_limit is
// written on its own channel, which is always ready; write it only while no request
// is in flight. A lowered limit trims the history at the next push. No clearing
// pass after reset.
`include "assert_macros.svh"

module bounded_undo_history
    import buh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_history_limit,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_req_type,
    input  logic [TAG_OUT_W-1:0] i_entry_tag,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_accepted,
    output logic [TAG_OUT_W-1:0] o_acted_tag,
    output logic                 o_can_undo,
    output logic                 o_can_redo,
    output logic [TAG_OUT_W-1:0] o_undo_tag,
    output logic [TAG_OUT_W-1:0] o_redo_tag,
    output logic                 o_is_dirty,
    output logic [CNT_W-1:0]     o_entry_count,
    output logic [CNT_W-1:0]     o_cursor_position
);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_limit;
    t_ptr r_oldest, n_oldest;
    t_cnt r_held, n_held;
    t_cnt r_cursor, n_cursor;
    t_cnt r_save, n_save;
    logic r_save_ok, n_save_ok;

    logic r_acc, n_acc;
    logic r_was_undo, n_was_undo;
    logic r_was_redo, n_was_redo;

    logic r_out_valid, n_out_valid;
    logic load_out;
    logic in_fire;

    logic                 r_o_acc;
    logic [TAG_OUT_W-1:0] r_o_acted, r_o_utag, r_o_rtag;
    logic                 r_o_cu, r_o_cr, r_o_dirty;
    t_cnt                 r_o_held, r_o_cursor;

    t_ring_req ring_req;
    t_tag      rd_a, rd_b;
    t_ptr      push_slot;
    logic      push_we;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_history_limit;
        end
    end

    // ---------------- pointer update on accept ----------------
    always_comb begin
        t_cnt           lim;
        t_cnt           hc0;
        logic           sr0;
        logic [CNT_W:0] hc1;
        t_cnt           drop;

        lim  = eff_limit(r_limit);
        hc0  = r_held;
        sr0  = r_save_ok;
        hc1  = '0;
        drop = '0;

        n_oldest   = r_oldest;
        n_held     = r_held;
        n_cursor   = r_cursor;
        n_save     = r_save;
        n_save_ok  = r_save_ok;
        n_acc      = r_acc;
        n_was_undo = r_was_undo;
        n_was_redo = r_was_redo;
        push_we    = 1'b0;
        push_slot  = '0;

        // drop the redo branch before appending
        if (r_cursor < r_held) begin
            hc0 = r_cursor;
            if (r_save_ok && (r_save > r_cursor)) begin
                sr0 = 1'b0;
            end
        end
        push_slot = slot_of(r_oldest, hc0);
        hc1       = (CNT_W+1)'(hc0) + (CNT_W+1)'(1);

        if (in_fire) begin
            n_acc      = 1'b0;
            n_was_undo = 1'b0;
            n_was_redo = 1'b0;
            case (i_req_type)
                REQ_PUSH: begin
                    push_we   = 1'b1;
                    n_acc     = 1'b1;
                    n_save_ok = sr0;
                    if (hc1 > (CNT_W+1)'(lim)) begin
                        drop     = CNT_W'(hc1 - (CNT_W+1)'(lim));
                        n_oldest = slot_of(r_oldest, drop);
                        n_held   = lim;
                        n_cursor = lim;
                        if (sr0) begin
                            if (r_save < drop) begin
                                n_save_ok = 1'b0;
                            end else begin
                                n_save = r_save - drop;
                            end
                        end
                    end else begin
                        n_held   = CNT_W'(hc1);
                        n_cursor = CNT_W'(hc1);
                    end
                end
                REQ_UNDO: begin
                    if (r_cursor != '0) begin
                        n_cursor   = r_cursor - CNT_W'(1);
                        n_acc      = 1'b1;
                        n_was_undo = 1'b1;
                    end
                end
                REQ_REDO: begin
                    if (r_cursor < r_held) begin
                        n_cursor   = r_cursor + CNT_W'(1);
                        n_acc      = 1'b1;
                        n_was_redo = 1'b1;
                    end
                end
                REQ_MARK: begin
                    n_save    = r_cursor;
                    n_save_ok = 1'b1;
                    n_acc     = 1'b1;
                end
                REQ_CLEAR: begin
                    n_oldest  = '0;
                    n_held    = '0;
                    n_cursor  = '0;
                    n_save    = '0;
                    n_save_ok = 1'b1;
                    n_acc     = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest   <= '0;
            r_held     <= '0;
            r_cursor   <= '0;
            r_save     <= '0;
            r_save_ok  <= 1'b1;
            r_acc      <= 1'b0;
            r_was_undo <= 1'b0;
            r_was_redo <= 1'b0;
        end else begin
            r_oldest   <= n_oldest;
            r_held     <= n_held;
            r_cursor   <= n_cursor;
            r_save     <= n_save;
            r_save_ok  <= n_save_ok;
            r_acc      <= n_acc;
            r_was_undo <= n_was_undo;
            r_was_redo <= n_was_redo;
        end
    end

    // ---------------- ring ----------------
    // reads use the settled pointers; the push write lands at the accept edge, before the read
    always_comb begin
        ring_req.we      = push_we;
        ring_req.waddr   = push_slot;
        ring_req.wdata   = t_tag'(i_entry_tag);
        ring_req.raddr_a = slot_of(r_oldest, r_cursor - CNT_W'(1));
        ring_req.raddr_b = slot_of(r_oldest, r_cursor);
    end

    buh_ring u_ring (
        .i_clk  (i_clk),
        .i_req  (ring_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- result register ----------------
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        logic cu;
        logic cr;
        cu = (r_cursor != '0);
        cr = (r_cursor < r_held);
        if (load_out) begin
            r_o_acc    <= r_acc;
            // undo lands on the new redo slot, redo on the new undo slot
            if (r_was_undo) begin
                r_o_acted <= TAG_OUT_W'(rd_b);
            end else if (r_was_redo) begin
                r_o_acted <= TAG_OUT_W'(rd_a);
            end else begin
                r_o_acted <= '0;
            end
            r_o_cu     <= cu;
            r_o_cr     <= cr;
            r_o_utag   <= cu ? TAG_OUT_W'(rd_a) : '0;
            r_o_rtag   <= cr ? TAG_OUT_W'(rd_b) : '0;
            r_o_dirty  <= !r_save_ok || (r_cursor != r_save);
            r_o_held   <= r_held;
            r_o_cursor <= r_cursor;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_o_acc;
    assign o_acted_tag       = r_o_acted;
    assign o_can_undo        = r_o_cu;
    assign o_can_redo        = r_o_cr;
    assign o_undo_tag        = r_o_utag;
    assign o_redo_tag        = r_o_rtag;
    assign o_is_dirty        = r_o_dirty;
    assign o_entry_count     = r_o_held;
    assign o_cursor_position = r_o_cursor;

    // ---------------- assertions ----------------
    `AST_INVAR(a_cursor_in_range, i_clk, i_rst_n, r_cursor <= r_held, "cursor above count")
    `AST_INVAR(a_held_in_range, i_clk, i_rst_n, 32'(r_held) <= HISTORY_DEPTH, "count above depth")
    `AST_PROP(a_save_in_range, i_clk, i_rst_n, r_save_ok |-> (r_save <= r_held), "save point lost")
    `AST_PROP(a_accept_reads, i_clk, i_rst_n, in_fire |=> (r_state == ST_READ), "no ring read")
    `AST_PROP(a_refused_no_tag, i_clk, i_rst_n, (o_out_valid && !o_accepted) |-> (o_acted_tag == '0), "tag on refusal")

endmodule

// ===== sim/tb_bounded_undo_history.sv =====
// Testbench for bounded_undo_history: directed and random requests checked by a scoreboard.
`timescale 1ns / 1ps

module tb_bounded_undo_history;
    import buh_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LATENCY_PAUSE  = 4;
    localparam int RANDOM_ITEMS   = 1130;
    localparam logic [2:0] REQ_UNKNOWN_LO  = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_MID = 3'd6;
    localparam logic [2:0] REQ_UNKNOWN_HI  = 3'd7;
    localparam logic [CFG_W-1:0] PRESET_LIMITS [7] = '{
        7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd8
    };

    typedef struct packed {
        logic accepted;
        t_tag acted_tag;
        logic can_undo;
        logic can_redo;
        t_tag undo_tag;
        t_tag redo_tag;
        logic is_dirty;
        t_cnt entry_count;
        t_cnt cursor_position;
    } t_history_outcome;

    class t_undo_history_tracker;
        t_tag ring [HISTORY_DEPTH];
        int oldest;
        int held;
        int cur;
        int saved_at;
        bit save_ok;
        logic [CFG_W-1:0] limit_reg;
        t_history_outcome pending[$];
        int mismatches;
        int results_seen;
        int pushes, undos, redos, refusals, marks, clears, unknowns;

        function new();
            foreach (ring[i]) ring[i] = '0;
            oldest = 0;
            held = 0;
            cur = 0;
            saved_at = 0;
            save_ok = 1'b1;
            limit_reg = LIMIT_RESET;
        endfunction

        function void set_limit(logic [CFG_W-1:0] v);
            limit_reg = v;
        endfunction

        function int slot(int pos);
            return (oldest + pos) % HISTORY_DEPTH;
        endfunction

        function void note_request(logic [2:0] req, t_tag tag);
            t_history_outcome o;
            int lim;
            int drop;
            o = '0;
            case (req)
                REQ_PUSH: begin
                    if (limit_reg == '0) lim = 1;
                    else if (int'(limit_reg) > HISTORY_DEPTH) lim = HISTORY_DEPTH;
                    else lim = int'(limit_reg);
                    // pushing below the top discards the redo branch
                    if (cur < held) begin
                        if (save_ok && saved_at > cur) save_ok = 1'b0;
                        held = cur;
                    end
                    ring[slot(held)] = tag;
                    held++;
                    cur = held;
                    if (held > lim) begin
                        drop = held - lim;
                        oldest = (oldest + drop) % HISTORY_DEPTH;
                        held = lim;
                        cur -= (cur < drop) ? cur : drop;
                        if (save_ok) begin
                            if (saved_at < drop) save_ok = 1'b0;
                            else saved_at -= drop;
                        end
                    end
                    o.accepted = 1'b1;
                    pushes++;
                end
                REQ_UNDO: begin
                    if (cur > 0) begin
                        o.acted_tag = ring[slot(cur - 1)];
                        cur--;
                        o.accepted = 1'b1;
                        undos++;
                    end else begin
                        refusals++;
                    end
                end
                REQ_REDO: begin
                    if (cur < held) begin
                        o.acted_tag = ring[slot(cur)];
                        cur++;
                        o.accepted = 1'b1;
                        redos++;
                    end else begin
                        refusals++;
                    end
                end
                REQ_MARK: begin
                    saved_at = cur;
                    save_ok = 1'b1;
                    o.accepted = 1'b1;
                    marks++;
                end
                REQ_CLEAR: begin
                    held = 0;
                    cur = 0;
                    saved_at = 0;
                    save_ok = 1'b1;
                    oldest = 0;
                    o.accepted = 1'b1;
                    clears++;
                end
                default: begin
                    unknowns++;
                end
            endcase
            o.can_undo = (cur > 0);
            o.can_redo = (cur < held);
            o.undo_tag = o.can_undo ? ring[slot(cur - 1)] : '0;
            o.redo_tag = o.can_redo ? ring[slot(cur)] : '0;
            o.is_dirty = !save_ok || (cur != saved_at);
            o.entry_count = t_cnt'(held);
            o.cursor_position = t_cnt'(cur);
            pending = {pending, o};
        endfunction

        function void flag(string what, logic [15:0] want, logic [15:0] seen);
            if (want !== seen) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in result %0d, %s: expected %0h, got %0h",
                             results_seen, what, want, seen);
            end
        endfunction

        function void check_outcome(t_history_outcome got);
            t_history_outcome want;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with no request outstanding", results_seen);
                return;
            end
            want = pending.pop_front();
            flag("accepted",        16'(want.accepted),        16'(got.accepted));
            flag("acted_tag",       want.acted_tag,            got.acted_tag);
            flag("can_undo",        16'(want.can_undo),        16'(got.can_undo));
            flag("can_redo",        16'(want.can_redo),        16'(got.can_redo));
            flag("undo_tag",        want.undo_tag,             got.undo_tag);
            flag("redo_tag",        want.redo_tag,             got.redo_tag);
            flag("is_dirty",        16'(want.is_dirty),        16'(got.is_dirty));
            flag("entry_count",     16'(want.entry_count),     16'(got.entry_count));
            flag("cursor_position", 16'(want.cursor_position), 16'(got.cursor_position));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_limit = '0;
    logic             in_valid = 1'b0;
    logic [2:0]       in_req = '0;
    t_tag             in_tag = '0;
    logic             out_ready = 1'b0;

    logic             o_cfg_ready;
    logic             o_in_ready;
    logic             o_out_valid;
    logic             o_accepted;
    t_tag             o_acted_tag;
    logic             o_can_undo;
    logic             o_can_redo;
    t_tag             o_undo_tag;
    t_tag             o_redo_tag;
    logic             o_is_dirty;
    t_cnt             o_entry_count;
    t_cnt             o_cursor_position;

    t_undo_history_tracker tracker = new();
    int burst_left = 0;
    int limit_writes = 0;
    int idle_cycles = 0;
    int rx_cycle = 0;
    int rx_mode = 0;

    bounded_undo_history dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_history_limit (cfg_limit),
        .i_in_valid          (in_valid),
        .o_in_ready          (o_in_ready),
        .i_req_type          (in_req),
        .i_entry_tag         (in_tag),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (out_ready),
        .o_accepted          (o_accepted),
        .o_acted_tag         (o_acted_tag),
        .o_can_undo          (o_can_undo),
        .o_can_redo          (o_can_redo),
        .o_undo_tag          (o_undo_tag),
        .o_redo_tag          (o_redo_tag),
        .o_is_dirty          (o_is_dirty),
        .o_entry_count       (o_entry_count),
        .o_cursor_position   (o_cursor_position)
    );

    always #5 clk = ~clk;

    // result side: check each transaction, stall in one of four randomly chosen ready modes
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                tracker.check_outcome({o_accepted, o_acted_tag, o_can_undo, o_can_redo,
                                       o_undo_tag, o_redo_tag, o_is_dirty, o_entry_count,
                                       o_cursor_position});
            end
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0) rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= $urandom_range(0, 1);
                default: out_ready <= (rx_cycle % 8 == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)
                    || (cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("bounded_undo_history test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic issue_request(input logic [2:0] req, input t_tag tag);
        in_valid <= 1'b1;
        in_req   <= req;
        in_tag   <= tag;
        do @(posedge clk); while (!o_in_ready);
        tracker.note_request(req, tag);
    endtask

    // sender bursts: long unbroken runs now and then, otherwise short ones with gaps
    task automatic send(input logic [2:0] req, input t_tag tag);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        issue_request(req, tag);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge clk);
        repeat (LATENCY_PAUSE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_limit <= v;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_limit(v);
        limit_writes++;
    endtask

    initial begin
        int phase;
        int phase_items;
        int random_sent;
        int push_pct;
        int pick;
        logic [2:0] req;
        t_tag tag;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // refusals on empty history, save point lost by a push below it, clear
        send(REQ_UNDO, 16'h0000);
        send(REQ_REDO, 16'hFFFF);
        send(REQ_UNKNOWN_HI, 16'hFFFF);
        send(REQ_PUSH, 16'h0000);
        send(REQ_PUSH, 16'hFFFF);
        send(REQ_PUSH, 16'h1234);
        send(REQ_MARK, 16'h0000);
        send(REQ_UNDO, 16'h0000);
        send(REQ_UNDO, 16'h0000);
        send(REQ_PUSH, 16'h5A5A);
        send(REQ_REDO, 16'h0000);
        send(REQ_UNKNOWN_LO, 16'h0000);
        send(REQ_MARK, 16'h0000);
        send(REQ_CLEAR, 16'h0000);
        send(REQ_UNKNOWN_MID, 16'h0000);

        // trimming shifts the save point, then drops it
        write_limit(7'd2);
        send(REQ_PUSH, 16'h0001);
        send(REQ_PUSH, 16'h0002);
        send(REQ_MARK, 16'h0000);
        send(REQ_PUSH, 16'h0003);
        send(REQ_PUSH, 16'h0004);
        send(REQ_PUSH, 16'h0005);

        // zero acts as one
        write_limit(7'd0);
        send(REQ_PUSH, 16'h0006);
        send(REQ_UNDO, 16'h0000);
        send(REQ_REDO, 16'h0000);

        // above the ring size, then lowered: nothing dropped until the next push
        write_limit(7'd127);
        send(REQ_PUSH, 16'hA5A5);
        send(REQ_PUSH, 16'h00FF);
        send(REQ_PUSH, 16'hFF00);
        write_limit(7'd3);
        send(REQ_UNDO, 16'h0000);
        send(REQ_REDO, 16'h0000);
        send(REQ_PUSH, 16'h8001);

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (phase < 7) write_limit(PRESET_LIMITS[phase]);
            else if ($urandom_range(0, 3) == 0) write_limit(CFG_W'($urandom_range(0, 127)));
            else write_limit(CFG_W'($urandom_range(1, 20)));
            // the first phase pushes hard so the full ring wraps
            push_pct = (phase == 0) ? 85 : $urandom_range(35, 75);
            phase_items = (phase == 0) ? 160 : $urandom_range(70, 120);
            if (phase_items > RANDOM_ITEMS - random_sent)
                phase_items = RANDOM_ITEMS - random_sent;
            repeat (phase_items) begin
                pick = $urandom_range(0, 99);
                if (pick < push_pct) begin
                    req = REQ_PUSH;
                end else begin
                    pick = $urandom_range(0, 19);
                    if (pick < 8) req = REQ_UNDO;
                    else if (pick < 14) req = REQ_REDO;
                    else if (pick < 17) req = REQ_MARK;
                    else if (pick < 18) req = REQ_CLEAR;
                    else req = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
                end
                case ($urandom_range(0, 9))
                    0: tag = '0;
                    1: tag = '1;
                    default: tag = t_tag'($urandom);
                endcase
                send(req, tag);
                random_sent++;
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        tracker.mismatches += tracker.pending.size();
        $display("%0d results checked: %0d push, %0d undo, %0d redo, %0d mark, %0d clear",
                 tracker.results_seen, tracker.pushes, tracker.undos, tracker.redos,
                 tracker.marks, tracker.clears);
        $display("%0d refused, %0d unknown requests, %0d limit settings, %0d mismatches",
                 tracker.refusals, tracker.unknowns, limit_writes, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("bounded_undo_history test passed");
        end else begin
            $display("bounded_undo_history test failed");
        end
        $finish;
    end

endmodule
